@@ rtl/core/mpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsm_pkg: shared types and constants of the multi-pattern string matcher
// Sizes, request and status codes, payload structs, controller states and
// the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsm_pkg;

  localparam int NODES       = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int SYM_W       = 5;
  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int CADDR_W     = $clog2(CHILD_DEPTH);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_SCAN   = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
  localparam logic [1:0] ST_WRONG_PHASE = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic       found;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_INS_EV,
    S_B_POP, S_B_CUR, S_B_FCUR, S_B_CHRD, S_B_CH, S_B_LINK, S_B_MARK,
    S_W_CHK, S_W_CH, S_W_FL,
    S_SC_MARK, S_SC_EV, S_RESP
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT,
    OP_INS_RD, OP_INS_EV, OP_INS_DROP, OP_WRONG,
    OP_B_INIT, OP_B_POP, OP_B_DONE, OP_B_CUR, OP_B_FCUR, OP_B_CHRD,
    OP_B_NEXT, OP_B_WALK, OP_B_LINK, OP_B_MARK,
    OP_W_ROOT, OP_W_RD, OP_W_HIT, OP_W_FRD, OP_W_FL,
    OP_SC_START, OP_SC_ROOT, OP_SC_MARK, OP_SC_EV, OP_RESP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] req;
    logic       sym_ok;
    logic       built;
    logic       dropped;
    logic       head_lt_tail;
    logic       ch_zero;
    logic       wn_zero;
    logic       s_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/mpsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpsm_ctrl: sequencing state machine of the matcher
// Steps through insert, build and scan work and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsm_ctrl import mpsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   build_q, build_d;   // walk belongs to the build pass

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      build_q <= build_d;
    end
  end

  always_comb begin
    state_d = state_q;
    build_d = build_q;
    unique case (state_q)
      S_CLEAR:    if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts_i.req)
          REQ_INSERT: begin
            if (sts_i.built) state_d = S_RESP;
            else if (sts_i.dropped) state_d = S_RESP;
            else state_d = S_INS_EV;
          end
          REQ_BUILD: state_d = sts_i.built ? S_RESP : S_B_POP;
          REQ_SCAN: begin
            build_d = 1'b0;
            if (!sts_i.built) state_d = S_RESP;
            else if (sts_i.sym_ok) state_d = S_W_CHK;
            else state_d = S_SC_MARK;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_INS_EV:  state_d = S_RESP;
      S_B_POP:   state_d = sts_i.head_lt_tail ? S_B_CUR : S_RESP;
      S_B_CUR:   state_d = S_B_FCUR;
      S_B_FCUR:  state_d = S_B_CHRD;
      S_B_CHRD:  state_d = S_B_CH;
      S_B_CH: begin
        if (sts_i.ch_zero) begin
          state_d = sts_i.s_last ? S_B_POP : S_B_CHRD;
        end else begin
          build_d = 1'b1;
          state_d = S_W_CHK;
        end
      end
      S_B_LINK:  state_d = S_B_MARK;
      S_B_MARK:  state_d = sts_i.s_last ? S_B_POP : S_B_CHRD;
      S_W_CHK: begin
        if (sts_i.wn_zero) state_d = build_q ? S_B_LINK : S_SC_MARK;
        else state_d = S_W_CH;
      end
      S_W_CH: begin
        if (!sts_i.ch_zero) state_d = build_q ? S_B_LINK : S_SC_MARK;
        else state_d = S_W_FL;
      end
      S_W_FL:    state_d = S_W_CHK;
      S_SC_MARK: state_d = S_SC_EV;
      S_SC_EV:   state_d = S_RESP;
      S_RESP:    if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_ACCEPT;
      end
      S_DISPATCH: begin
        unique case (sts_i.req)
          REQ_INSERT: begin
            if (sts_i.built) cmd_o.op = OP_WRONG;
            else if (sts_i.dropped) cmd_o.op = OP_INS_DROP;
            else cmd_o.op = OP_INS_RD;
          end
          REQ_BUILD: cmd_o.op = sts_i.built ? OP_WRONG : OP_B_INIT;
          REQ_SCAN: begin
            if (!sts_i.built) cmd_o.op = OP_WRONG;
            else if (sts_i.sym_ok) cmd_o.op = OP_SC_START;
            else cmd_o.op = OP_SC_ROOT;
          end
          default: cmd_o.op = OP_WRONG;
        endcase
      end
      S_INS_EV:  cmd_o.op = OP_INS_EV;
      S_B_POP:   cmd_o.op = sts_i.head_lt_tail ? OP_B_POP : OP_B_DONE;
      S_B_CUR:   cmd_o.op = OP_B_CUR;
      S_B_FCUR:  cmd_o.op = OP_B_FCUR;
      S_B_CHRD:  cmd_o.op = OP_B_CHRD;
      S_B_CH:    cmd_o.op = sts_i.ch_zero ? OP_B_NEXT : OP_B_WALK;
      S_B_LINK:  cmd_o.op = OP_B_LINK;
      S_B_MARK:  cmd_o.op = OP_B_MARK;
      S_W_CHK:   cmd_o.op = sts_i.wn_zero ? OP_W_ROOT : OP_W_RD;
      S_W_CH:    cmd_o.op = sts_i.ch_zero ? OP_W_FRD : OP_W_HIT;
      S_W_FL:    cmd_o.op = OP_W_FL;
      S_SC_MARK: cmd_o.op = OP_SC_MARK;
      S_SC_EV:   cmd_o.op = OP_SC_EV;
      S_RESP:    if (sts_i.out_free) cmd_o.op = OP_RESP;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/mpsm_dp.sv @@
// ----------------------------------------------------------------------------
// mpsm_dp: datapath of the matcher
// Holds the trie memories, the build queue, cursors, flags and the output
// register, and carries out one controller command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsm_dp import mpsm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output out_item_t      out_data_o,
  input  wire cmd_t      cmd_i,
  output sts_t           sts_o
);

  logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
  logic [NODE_W-1:0] fail_mem  [NODES];
  logic              mark_mem  [NODES];
  logic [NODE_W-1:0] queue_mem [NODES];

  logic [CADDR_W-1:0] clr_q;
  in_item_t           item_q;
  logic [NODE_W-1:0]  ins_cur_q, scan_cur_q, cur_q, fc_q, p_q, wn_q, wt_q;
  logic [CNT_W-1:0]   nc_q, head_q, tail_q;
  logic [SYM_W-1:0]   sidx_q, ws_q;
  logic               built_q, found_q, drop_q, out_valid_q;
  out_item_t          res_q, out_q;

  logic [NODE_W-1:0] child_rd_q, fail_rd_q, queue_rd_q;
  logic              mark_rd_q;

  logic               sym_ok;
  logic [NODE_W-1:0]  addr_node;
  logic [SYM_W-1:0]   addr_sym;
  logic [CADDR_W-1:0] child_addr;
  logic               child_we;
  logic [NODE_W-1:0]  child_wd;
  logic               fail_we, mark_we, mark_wd, queue_we;
  logic [NODE_W-1:0]  fail_wa, fail_wd, fail_ra, mark_wa, mark_ra;
  logic [NODE_W-1:0]  queue_wa, queue_wd;
  logic [NODE_W-1:0]  ins_c;
  logic               ins_alloc;
  logic               sc_hit;

  assign sym_ok = item_q.symbol < SYM_W'(ALPHABET);

  // Insert evaluation: existing child, a freshly allocated node, or null.
  always_comb begin
    ins_alloc = 1'b0;
    ins_c     = sym_ok ? child_rd_q : '0;
    if (ins_c == '0 && sym_ok && nc_q < CNT_W'(NODES)) begin
      ins_alloc = 1'b1;
      ins_c     = nc_q[NODE_W-1:0];
    end
  end

  assign sc_hit = mark_rd_q;

  // Child table address: node times alphabet plus letter, or the clear counter.
  always_comb begin
    addr_node = '0;
    addr_sym  = '0;
    case (cmd_i.op)
      OP_INS_RD, OP_INS_EV: begin
        addr_node = sym_ok ? ins_cur_q : '0;
        addr_sym  = sym_ok ? item_q.symbol : '0;
      end
      OP_B_FCUR, OP_B_CHRD: begin
        addr_node = cur_q;
        addr_sym  = sidx_q;
      end
      OP_W_RD: begin
        addr_node = wn_q;
        addr_sym  = ws_q;
      end
      default: ;
    endcase
    if (cmd_i.op == OP_CLEAR) begin
      child_addr = clr_q;
    end else begin
      child_addr = CADDR_W'(addr_node) * CADDR_W'(ALPHABET) + CADDR_W'(addr_sym);
    end
  end

  always_comb begin
    child_we = 1'b0;
    child_wd = '0;
    fail_we  = 1'b0;
    fail_wa  = '0;
    fail_wd  = '0;
    fail_ra  = wn_q;
    mark_we  = 1'b0;
    mark_wa  = '0;
    mark_wd  = 1'b0;
    mark_ra  = wt_q;
    queue_we = 1'b0;
    queue_wa = '0;
    queue_wd = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        child_we = 1'b1;
        mark_we  = clr_q < CADDR_W'(NODES);
        mark_wa  = clr_q[NODE_W-1:0];
      end
      OP_INS_EV: begin
        child_we = ins_alloc;
        child_wd = ins_c;
        mark_we  = (ins_c != '0) && item_q.last;
        mark_wa  = ins_c;
        mark_wd  = 1'b1;
      end
      OP_B_INIT: begin
        fail_we  = 1'b1;
        fail_wa  = NODE_W'(1);
        queue_we = 1'b1;
        queue_wd = NODE_W'(1);
      end
      OP_B_CUR: fail_ra = queue_rd_q;
      OP_B_LINK: begin
        fail_we  = 1'b1;
        fail_wa  = p_q;
        fail_wd  = wt_q;
        queue_we = tail_q < CNT_W'(NODES);
        queue_wa = tail_q[NODE_W-1:0];
        queue_wd = p_q;
      end
      OP_B_MARK: begin
        mark_we = mark_rd_q;
        mark_wa = p_q;
        mark_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_addr] <= child_wd;
    child_rd_q <= child_mem[child_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_q <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd_q <= queue_mem[head_q[NODE_W-1:0]];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      ins_cur_q   <= NODE_W'(1);
      scan_cur_q  <= NODE_W'(1);
      nc_q        <= CNT_W'(2);
      head_q      <= '0;
      tail_q      <= '0;
      sidx_q      <= '0;
      built_q     <= 1'b0;
      found_q     <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RESP) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_CLEAR: clr_q <= clr_q + 1'b1;
        OP_INS_DROP: begin
          if (item_q.last) begin
            drop_q    <= 1'b0;
            ins_cur_q <= NODE_W'(1);
          end
        end
        OP_INS_EV: begin
          if (ins_alloc) nc_q <= nc_q + 1'b1;
          if (ins_c == '0) begin
            if (item_q.last) ins_cur_q <= NODE_W'(1);
            else drop_q <= 1'b1;
          end else if (item_q.last) begin
            ins_cur_q <= NODE_W'(1);
          end else begin
            ins_cur_q <= ins_c;
          end
        end
        OP_B_INIT: begin
          head_q <= '0;
          tail_q <= CNT_W'(1);
        end
        OP_B_POP: head_q <= head_q + 1'b1;
        OP_B_DONE: begin
          built_q    <= 1'b1;
          scan_cur_q <= NODE_W'(1);
          found_q    <= 1'b0;
        end
        OP_B_CUR: sidx_q <= '0;
        OP_B_NEXT, OP_B_MARK: sidx_q <= sidx_q + 1'b1;
        OP_B_LINK: if (tail_q < CNT_W'(NODES)) tail_q <= tail_q + 1'b1;
        OP_SC_EV: begin
          if (item_q.last) begin
            scan_cur_q <= NODE_W'(1);
            found_q    <= 1'b0;
          end else begin
            scan_cur_q <= wt_q;
            found_q    <= found_q | sc_hit;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT:   item_q <= in_data_i;
      OP_WRONG:    res_q  <= '{hit: 1'b0, found: 1'b0, status: ST_WRONG_PHASE};
      OP_INS_DROP: res_q  <= '{hit: 1'b0, found: 1'b0, status: ST_TABLE_FULL};
      OP_INS_EV: begin
        res_q <= '{hit: 1'b0, found: 1'b0,
                   status: (ins_c == '0) ? ST_TABLE_FULL : ST_OK};
      end
      OP_B_DONE:   res_q  <= '{hit: 1'b0, found: 1'b0, status: ST_OK};
      OP_B_CUR:    cur_q  <= queue_rd_q;
      OP_B_FCUR:   fc_q   <= fail_rd_q;
      OP_B_WALK: begin
        p_q  <= child_rd_q;
        wn_q <= fc_q;
        ws_q <= sidx_q;
      end
      OP_W_ROOT:   wt_q   <= NODE_W'(1);
      OP_W_HIT:    wt_q   <= child_rd_q;
      OP_W_FL:     wn_q   <= fail_rd_q;
      OP_SC_START: begin
        wn_q <= scan_cur_q;
        ws_q <= item_q.symbol;
      end
      OP_SC_ROOT:  wt_q   <= NODE_W'(1);
      OP_SC_EV: begin
        res_q <= '{hit: sc_hit, found: found_q | sc_hit, status: ST_OK};
      end
      OP_RESP:     out_q  <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.clr_last     = clr_q == CADDR_W'(CHILD_DEPTH - 1);
    sts_o.req          = item_q.req_type;
    sts_o.sym_ok       = sym_ok;
    sts_o.built        = built_q;
    sts_o.dropped      = drop_q;
    sts_o.head_lt_tail = head_q < tail_q;
    sts_o.ch_zero      = child_rd_q == '0;
    sts_o.wn_zero      = wn_q == '0;
    sts_o.s_last       = sidx_q == SYM_W'(ALPHABET - 1);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/multi_pattern_string_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher: Aho-Corasick matcher over 26 letters
// Every request item on the input channel gives one result item on the
// output channel, in order. Insert items grow the trie, one build item
// computes failure links, and scan items walk the text.
// Usage:
//   Both channels use valid/ready; a transfer happens when both are high.
//   One item is worked on at a time. A scan follows failure links in a
//   serial walk over the single-port child table; a letter outside the
//   alphabet goes straight back to the root. The build visits every trie
//   node and every letter of the alphabet per node, and runs the failure
//   walk for every child.
//   After reset, a clearing pass writes every child table entry to null;
//   no item is taken during it.
//   A finished result sits in an output register. A new item is taken while
//   it waits; its result waits in turn until the receiver takes the older one.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_string_matcher import mpsm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  cmd_t cmd;
  sts_t sts;

  mpsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpsm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
